// File: rtl/humidity_temp_sensor_poller_unit_defines.svh
// ----------------------------------------------------------------------------
// humidity/temperature sensor poller - assertion macros
// shared property forms for the checker attached to the poller
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_SENSOR_POLLER_UNIT_DEFINES_SVH
`define HUMIDITY_TEMP_SENSOR_POLLER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define HTSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htsp: same-cycle property failed");

// next-cycle implication, held off during reset
`define HTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htsp: next-cycle property failed");

`endif

// File: rtl/htsp_pkg.sv
// ----------------------------------------------------------------------------
// htsp_pkg
// codes, command words and reset values of the sensor poller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htsp_pkg;

    // event kinds of an input word
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_MEASURE  = 2'd1;
    localparam logic [1:0] CMD_BUS_DONE = 2'd2;

    // requested bus actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_WR_RST  = 2'd1;
    localparam logic [1:0] ACT_WR_MEAS = 2'd2;
    localparam logic [1:0] ACT_RD_DATA = 2'd3;

    // reported events
    localparam logic [1:0] EVT_NONE   = 2'd0;
    localparam logic [1:0] EVT_UPDATE = 2'd1;
    localparam logic [1:0] EVT_ERROR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_UPDATE_INTERVAL = 2'd0;
    localparam logic [1:0] REG_INIT_DELAY      = 2'd1;
    localparam logic [1:0] REG_MEASURE_DELAY   = 2'd2;
    localparam logic [1:0] REG_DEVICE_ADDRESS  = 2'd3;

    // command words in transmitted byte order
    localparam logic [15:0] WORD_SOFT_RESET = 16'h30A2;
    localparam logic [15:0] WORD_MEASURE    = 16'h2C0D;

    // interval value meaning no automatic measurement
    localparam logic [31:0] INTERVAL_NEVER = 32'hFFFF_FFFF;

    // register reset values
    localparam logic [7:0] INIT_DELAY_RST    = 8'd20;
    localparam logic [7:0] MEASURE_DELAY_RST = 8'd20;
    localparam logic [6:0] DEV_ADDR_RST      = 7'd68;

    // fixed-point conversion
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [13:0] HUM_MAX     = 14'd10000;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
    localparam logic [15:0] ROUND_HALF  = 16'h7FFF;

endpackage

// File: rtl/humidity_temp_sensor_poller_unit.sv
// ----------------------------------------------------------------------------
// humidity_temp_sensor_poller_unit
// sequences a humidity/temperature sensor: soft reset, measure, read
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                     | word
//  ---------+-----------+-------------------------------+---------------------------
//  in       | sink      | i_in_valid  / o_in_stall      | cmd, bus_ok, read words
//  out      | source    | o_out_valid / i_out_stall     | bus request, event, readings
//  cfg      | sink      | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
//  one word a cycle sustained while the result side does not stall; a result is
//  offered once its input word has passed the input register, then the
//  sequencer update and the result register
//  the conversion path (a constant multiply per reading, then a fold-and-compare
//  division by full scale) sits between the two registers
//  i_rst_n is synchronous, active low; no clearing pass is needed
//  a stall on the result side holds the result and the input register, and
//  then stalls the input side; the cfg port is always ready
//
`timescale 1ns / 1ps

module humidity_temp_sensor_poller_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic               i_bus_ok,
    input  logic [15:0]        i_read_temp_word,
    input  logic [15:0]        i_read_hum_word,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_bus_action,
    output logic [15:0]        o_bus_word,
    output logic [6:0]         o_bus_address,
    output logic [1:0]         o_event_code,
    output logic               o_measure_accepted,
    output logic               o_readings_valid,
    output logic [15:0]        o_humidity_raw_out,
    output logic [15:0]        o_temperature_raw_out,
    output logic [13:0]        o_humidity_pct,
    output logic signed [14:0] o_temp_centi_c,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    // sequencer phase
    typedef enum logic [1:0] {
        PH_RESET,
        PH_MEASURE,
        PH_READ
    } t_phase;

    // floor(x / 65535) for x below 2^31: fold the high half back in, then
    // one compare corrects the quotient since the remainder stays below 2 * 65535
    function automatic logic [15:0] div_full_scale(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r0;
        begin
            q0 = x[30:16];
            r0 = {1'b0, x[15:0]} + {2'b00, q0};
            div_full_scale = {1'b0, q0} +
                ((r0 >= {1'b0, htsp_pkg::FULL_SCALE}) ? 16'd1 : 16'd0);
        end
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_update_interval, n_update_interval;
    logic [7:0]  r_init_delay,      n_init_delay;
    logic [7:0]  r_measure_delay,   n_measure_delay;
    logic [6:0]  r_device_address,  n_device_address;

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    t_phase      r_phase,        n_phase;
    logic        r_meas_active,  n_meas_active;
    logic        r_await_bus,    n_await_bus;
    logic        r_wake_pending, n_wake_pending;
    logic [7:0]  r_wake_cnt,     n_wake_cnt;
    logic [7:0]  r_ready_cnt,    n_ready_cnt;
    logic [31:0] r_interval_cnt, n_interval_cnt;
    logic [15:0] r_hum_word,     n_hum_word;
    logic [15:0] r_temp_word,    n_temp_word;
    logic        r_valid_flag,   n_valid_flag;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic        r_s1_valid;
    logic [1:0]  r_s1_cmd;
    logic        r_s1_bus_ok;
    logic [15:0] r_s1_temp;
    logic [15:0] r_s1_hum;

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic        r_out_valid;
    logic [1:0]  r_bus_action,  n_bus_action;
    logic [15:0] r_bus_word,    n_bus_word;
    logic [6:0]  r_bus_address;
    logic [1:0]  r_event_code,  n_event_code;
    logic        r_meas_acc,    n_meas_acc;
    logic [13:0] r_hum_pct;
    logic [14:0] r_temp_centi;

    // handshake
    logic in_take;
    logic out_take;
    logic advance;
    logic cfg_wr;

    // conversion datapath
    logic [29:0] hum_prod;
    logic [30:0] temp_prod;
    logic [15:0] hum_q;
    logic [15:0] temp_q;
    logic [13:0] hum_sat;
    logic [15:0] temp_off;

    // the input register moves on whenever the result slot is free or emptying
    assign out_take   = r_out_valid && !i_out_stall;
    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr     = i_cfg_valid;

    // ------------------------------------------------------------------
    // sequencer next state and result fields
    // ------------------------------------------------------------------
    always_comb begin
        n_update_interval = r_update_interval;
        n_init_delay      = r_init_delay;
        n_measure_delay   = r_measure_delay;
        n_device_address  = r_device_address;
        n_phase           = r_phase;
        n_meas_active     = r_meas_active;
        n_await_bus       = r_await_bus;
        n_wake_pending    = r_wake_pending;
        n_wake_cnt        = r_wake_cnt;
        n_ready_cnt       = r_ready_cnt;
        n_interval_cnt    = r_interval_cnt;
        n_hum_word        = r_hum_word;
        n_temp_word       = r_temp_word;
        n_valid_flag      = r_valid_flag;
        n_bus_action      = htsp_pkg::ACT_NONE;
        n_bus_word        = 16'd0;
        n_event_code      = htsp_pkg::EVT_NONE;
        n_meas_acc        = 1'b0;

        if (cfg_wr) begin
            // the user must write only while no word is in flight; not enforced here
            case (i_cfg_index)
                htsp_pkg::REG_UPDATE_INTERVAL: begin
                    n_update_interval = i_cfg_data;
                    n_interval_cnt    = i_cfg_data;
                    if (i_cfg_data != htsp_pkg::INTERVAL_NEVER && !r_meas_active) begin
                        n_meas_active  = 1'b1;
                        n_wake_pending = 1'b1;
                        n_wake_cnt     = r_ready_cnt;
                    end
                end
                htsp_pkg::REG_INIT_DELAY:    n_init_delay     = i_cfg_data[7:0];
                htsp_pkg::REG_MEASURE_DELAY: n_measure_delay  = i_cfg_data[7:0];
                htsp_pkg::REG_DEVICE_ADDRESS: n_device_address = i_cfg_data[6:0];
                default: ;
            endcase
        end else if (advance) begin
            case (r_s1_cmd)
                htsp_pkg::CMD_TICK: begin
                    if (n_ready_cnt != 8'd0)
                        n_ready_cnt = n_ready_cnt - 8'd1;
                    // interval timer issues its own measure request
                    if (r_update_interval != htsp_pkg::INTERVAL_NEVER) begin
                        if (n_interval_cnt != 32'd0)
                            n_interval_cnt = n_interval_cnt - 32'd1;
                        if (n_interval_cnt == 32'd0) begin
                            if (!n_meas_active) begin
                                n_meas_active  = 1'b1;
                                n_wake_pending = 1'b1;
                                n_wake_cnt     = n_ready_cnt;
                            end
                            n_interval_cnt = r_update_interval;
                        end
                    end
                    // wake-up countdown, then the phase issues its bus action
                    if (n_wake_pending) begin
                        if (n_wake_cnt != 8'd0)
                            n_wake_cnt = n_wake_cnt - 8'd1;
                        if (n_wake_cnt == 8'd0 && !r_await_bus) begin
                            n_wake_pending = 1'b0;
                            n_await_bus    = 1'b1;
                            case (r_phase)
                                PH_RESET: begin
                                    n_bus_action = htsp_pkg::ACT_WR_RST;
                                    n_bus_word   = htsp_pkg::WORD_SOFT_RESET;
                                end
                                PH_MEASURE: begin
                                    n_bus_action = htsp_pkg::ACT_WR_MEAS;
                                    n_bus_word   = htsp_pkg::WORD_MEASURE;
                                end
                                default: begin
                                    n_bus_action = htsp_pkg::ACT_RD_DATA;
                                end
                            endcase
                        end
                    end
                end
                htsp_pkg::CMD_MEASURE: begin
                    if (!r_meas_active) begin
                        n_meas_active  = 1'b1;
                        n_wake_pending = 1'b1;
                        n_wake_cnt     = r_ready_cnt;
                        n_meas_acc     = 1'b1;
                    end
                end
                htsp_pkg::CMD_BUS_DONE: begin
                    // a completion with nothing outstanding is ignored
                    if (r_await_bus) begin
                        n_await_bus = 1'b0;
                        if (!r_s1_bus_ok) begin
                            n_valid_flag   = 1'b0;
                            n_meas_active  = 1'b0;
                            n_wake_pending = 1'b0;
                            n_phase        = PH_RESET;
                            n_event_code   = htsp_pkg::EVT_ERROR;
                        end else begin
                            case (r_phase)
                                PH_RESET: begin
                                    n_phase     = PH_MEASURE;
                                    n_ready_cnt = r_init_delay;
                                    if (r_meas_active) begin
                                        n_wake_pending = 1'b1;
                                        n_wake_cnt     = r_init_delay;
                                    end
                                end
                                PH_MEASURE: begin
                                    n_phase        = PH_READ;
                                    n_wake_pending = 1'b1;
                                    n_wake_cnt     = r_measure_delay;
                                end
                                default: begin
                                    n_temp_word    = r_s1_temp;
                                    n_hum_word     = r_s1_hum;
                                    n_valid_flag   = 1'b1;
                                    n_meas_active  = 1'b0;
                                    n_wake_pending = 1'b0;
                                    n_phase        = PH_MEASURE;
                                    n_event_code   = htsp_pkg::EVT_UPDATE;
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // fixed-point conversion of the stored words after this step
    // ------------------------------------------------------------------
    assign hum_prod  = 30'(n_hum_word) * 30'(htsp_pkg::HUM_SCALE)
                     + 30'(htsp_pkg::ROUND_HALF);
    assign temp_prod = 31'(n_temp_word) * 31'(htsp_pkg::TEMP_SCALE)
                     + 31'(htsp_pkg::ROUND_HALF);
    assign hum_q     = div_full_scale({1'b0, hum_prod});
    assign temp_q    = div_full_scale(temp_prod);
    assign hum_sat   = (hum_q > {2'b00, htsp_pkg::HUM_MAX}) ? htsp_pkg::HUM_MAX : hum_q[13:0];
    assign temp_off  = temp_q - htsp_pkg::TEMP_OFFSET;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_interval <= htsp_pkg::INTERVAL_NEVER;
            r_init_delay      <= htsp_pkg::INIT_DELAY_RST;
            r_measure_delay   <= htsp_pkg::MEASURE_DELAY_RST;
            r_device_address  <= htsp_pkg::DEV_ADDR_RST;
            r_phase           <= PH_RESET;
            r_meas_active     <= 1'b0;
            r_await_bus       <= 1'b0;
            r_wake_pending    <= 1'b1;
            r_wake_cnt        <= htsp_pkg::INIT_DELAY_RST;
            r_ready_cnt       <= htsp_pkg::INIT_DELAY_RST;
            r_interval_cnt    <= htsp_pkg::INTERVAL_NEVER;
            r_hum_word        <= 16'd0;
            r_temp_word       <= 16'd0;
            r_valid_flag      <= 1'b0;
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_update_interval <= n_update_interval;
            r_init_delay      <= n_init_delay;
            r_measure_delay   <= n_measure_delay;
            r_device_address  <= n_device_address;
            r_phase           <= n_phase;
            r_meas_active     <= n_meas_active;
            r_await_bus       <= n_await_bus;
            r_wake_pending    <= n_wake_pending;
            r_wake_cnt        <= n_wake_cnt;
            r_ready_cnt       <= n_ready_cnt;
            r_interval_cnt    <= n_interval_cnt;
            r_hum_word        <= n_hum_word;
            r_temp_word       <= n_temp_word;
            r_valid_flag      <= n_valid_flag;

            if (in_take)
                r_s1_valid <= 1'b1;
            else if (advance)
                r_s1_valid <= 1'b0;

            if (advance)
                r_out_valid <= 1'b1;
            else if (out_take)
                r_out_valid <= 1'b0;
        end
    end

    // payload of the input and result registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd    <= i_cmd;
            r_s1_bus_ok <= i_bus_ok;
            r_s1_temp   <= i_read_temp_word;
            r_s1_hum    <= i_read_hum_word;
        end
        if (advance) begin
            r_bus_action  <= n_bus_action;
            r_bus_word    <= n_bus_word;
            r_bus_address <= (n_bus_action != htsp_pkg::ACT_NONE) ? r_device_address : 7'd0;
            r_event_code  <= n_event_code;
            r_meas_acc    <= n_meas_acc;
            r_hum_pct     <= hum_sat;
            r_temp_centi  <= temp_off[14:0];
        end
    end

    // ------------------------------------------------------------------
    // outputs; raw words and valid flag only move when a result is loaded
    // ------------------------------------------------------------------
    assign o_out_valid           = r_out_valid;
    assign o_bus_action          = r_bus_action;
    assign o_bus_word            = r_bus_word;
    assign o_bus_address         = r_bus_address;
    assign o_event_code          = r_event_code;
    assign o_measure_accepted    = r_meas_acc;
    assign o_readings_valid      = r_valid_flag;
    assign o_humidity_raw_out    = r_hum_word;
    assign o_temperature_raw_out = r_temp_word;
    assign o_humidity_pct        = r_hum_pct;
    assign o_temp_centi_c        = r_temp_centi;

endmodule

// File: rtl/htsp_checker.sv
// ----------------------------------------------------------------------------
// htsp_checker
// port-level checks of the sensor poller, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "humidity_temp_sensor_poller_unit_defines.svh"

module htsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_bus_action,
    input logic [15:0]        o_bus_word,
    input logic [6:0]         o_bus_address,
    input logic [1:0]         o_event_code,
    input logic               o_readings_valid,
    input logic [13:0]        o_humidity_pct
);

    // no bus request means no address and no command word
    `HTSP_ASSERT_SAME(a_idle_bus_quiet, i_clk, i_rst_n, o_out_valid && o_bus_action == htsp_pkg::ACT_NONE, o_bus_address == 7'd0 && o_bus_word == 16'd0)

    // an update always leaves valid readings
    `HTSP_ASSERT_SAME(a_update_valid, i_clk, i_rst_n, o_out_valid && o_event_code == htsp_pkg::EVT_UPDATE, o_readings_valid)

    // an error drops the readings and requests nothing on the bus
    `HTSP_ASSERT_SAME(a_error_clears, i_clk, i_rst_n, o_out_valid && o_event_code == htsp_pkg::EVT_ERROR, !o_readings_valid && o_bus_action == htsp_pkg::ACT_NONE)

    // humidity is saturated to full percent
    `HTSP_ASSERT_SAME(a_hum_range, i_clk, i_rst_n, o_out_valid, o_humidity_pct <= htsp_pkg::HUM_MAX)

    // a stalled result stays offered
    `HTSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

endmodule

bind humidity_temp_sensor_poller_unit htsp_checker u_htsp_checker (.*);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the humidity/temperature sensor poller: a scripted
// bring-up walks every sequencer phase, then random event streams run under
// several register settings, each result word checked against a local model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT = 300000;
    // event code the block must treat as an idle step
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // sequencer phases as kept by the local model
    typedef enum logic [1:0] {
        SEQ_SOFT_RESET,
        SEQ_MEASURE,
        SEQ_READ
    } t_seq_phase;

    // one result word, fields in port order
    typedef struct packed {
        logic [1:0]  bus_action;
        logic [15:0] bus_word;
        logic [6:0]  bus_address;
        logic [1:0]  event_code;
        logic        measure_accepted;
        logic        readings_valid;
        logic [15:0] humidity_raw;
        logic [15:0] temperature_raw;
        logic [13:0] humidity_pct;
        logic [14:0] temp_centi_c;
    } t_reading;

    // bring-up step: event, repeat count, and fields typed in where obvious
    typedef struct {
        logic [1:0]         cmd;
        logic               bus_ok;
        logic [15:0]        temp_word;
        logic [15:0]        hum_word;
        int unsigned        repeats;
        bit                 pinned;
        logic [1:0]         bus_action;
        logic [1:0]         event_code;
        logic [13:0]        humidity_pct;
        logic signed [14:0] temp_centi_c;
    } t_bringup_step;

    // ports; the inputs are known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_cmd = htsp_pkg::CMD_TICK;
    logic               i_bus_ok = 1'b0;
    logic [15:0]        i_read_temp_word = '0;
    logic [15:0]        i_read_hum_word = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_bus_action;
    logic [15:0]        o_bus_word;
    logic [6:0]         o_bus_address;
    logic [1:0]         o_event_code;
    logic               o_measure_accepted;
    logic               o_readings_valid;
    logic [15:0]        o_humidity_raw_out;
    logic [15:0]        o_temperature_raw_out;
    logic [13:0]        o_humidity_pct;
    logic signed [14:0] o_temp_centi_c;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = htsp_pkg::REG_UPDATE_INTERVAL;
    logic [31:0]        i_cfg_data = '0;

    int          faults = 0;
    int unsigned cycle_count = 0;
    // set for stretches with no idling on either side
    bit          calm = 1'b0;

    t_reading pending_readings[$];

    // local model: registers
    logic [31:0] cfg_interval;
    logic [7:0]  cfg_init_delay;
    logic [7:0]  cfg_measure_delay;
    logic [6:0]  cfg_address;
    // local model: sequencer state
    t_seq_phase  seq_phase;
    bit          meas_active;
    bit          bus_pending;
    bit          wake_armed;
    int unsigned wake_count;
    int unsigned ready_count;
    logic [31:0] interval_count;
    logic [15:0] hum_store;
    logic [15:0] temp_store;
    bit          store_valid;

    humidity_temp_sensor_poller_unit u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_cmd                 (i_cmd),
        .i_bus_ok              (i_bus_ok),
        .i_read_temp_word      (i_read_temp_word),
        .i_read_hum_word       (i_read_hum_word),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_bus_action          (o_bus_action),
        .o_bus_word            (o_bus_word),
        .o_bus_address         (o_bus_address),
        .o_event_code          (o_event_code),
        .o_measure_accepted    (o_measure_accepted),
        .o_readings_valid      (o_readings_valid),
        .o_humidity_raw_out    (o_humidity_raw_out),
        .o_temperature_raw_out (o_temperature_raw_out),
        .o_humidity_pct        (o_humidity_pct),
        .o_temp_centi_c        (o_temp_centi_c),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    // scripted bring-up, run with init and measure delays of zero; the
    // power-up wake still counts the reset value of the init delay
    t_bringup_step bringup_steps [25] = '{
        // after reset: nothing stored, idle step, stray completion ignored
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b1,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     -15'sd4500},
        '{CMD_UNUSED,             1'b1, 16'hFFFF, 16'hFFFF,  1, 1'b1,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     -15'sd4500},
        '{htsp_pkg::CMD_BUS_DONE, 1'b1, 16'hFFFF, 16'hFFFF,  1, 1'b1,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     -15'sd4500},
        // request taken, then refused while active
        '{htsp_pkg::CMD_MEASURE,  1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_MEASURE,  1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        // run out the power-up wait
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000, 18, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b1,
          htsp_pkg::ACT_WR_RST,  htsp_pkg::EVT_NONE,   14'd0,     -15'sd4500},
        // tick while the transfer is still out
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_BUS_DONE, 1'b1, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b1,
          htsp_pkg::ACT_WR_MEAS, htsp_pkg::EVT_NONE,   14'd0,     -15'sd4500},
        '{htsp_pkg::CMD_BUS_DONE, 1'b1, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b1,
          htsp_pkg::ACT_RD_DATA, htsp_pkg::EVT_NONE,   14'd0,     -15'sd4500},
        // full-scale words: humidity and temperature at the top of their scales
        '{htsp_pkg::CMD_BUS_DONE, 1'b1, 16'hFFFF, 16'hFFFF,  1, 1'b1,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_UPDATE, 14'd10000, 15'sd13000},
        // the next measurement skips the soft reset
        '{htsp_pkg::CMD_MEASURE,  1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_BUS_DONE, 1'b1, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        // zero words: bottom of both scales
        '{htsp_pkg::CMD_BUS_DONE, 1'b1, 16'h0000, 16'h0000,  1, 1'b1,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_UPDATE, 14'd0,     -15'sd4500},
        // failed measure write: error, back to soft reset, sequencer stops
        '{htsp_pkg::CMD_MEASURE,  1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_BUS_DONE, 1'b0, 16'h0000, 16'h0000,  1, 1'b1,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_ERROR,  14'd0,     -15'sd4500},
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        // new request restarts from the soft reset, which fails too
        '{htsp_pkg::CMD_MEASURE,  1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_TICK,     1'b0, 16'h0000, 16'h0000,  1, 1'b0,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_NONE,   14'd0,     15'sd0},
        '{htsp_pkg::CMD_BUS_DONE, 1'b0, 16'h1234, 16'hABCD,  1, 1'b1,
          htsp_pkg::ACT_NONE,    htsp_pkg::EVT_ERROR,  14'd0,     -15'sd4500}
    };

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // local model of the poller
    // ------------------------------------------------------------------------

    function automatic void reset_poller_model();
        cfg_interval      = htsp_pkg::INTERVAL_NEVER;
        cfg_init_delay    = htsp_pkg::INIT_DELAY_RST;
        cfg_measure_delay = htsp_pkg::MEASURE_DELAY_RST;
        cfg_address       = htsp_pkg::DEV_ADDR_RST;
        seq_phase         = SEQ_SOFT_RESET;
        meas_active       = 1'b0;
        bus_pending       = 1'b0;
        wake_armed        = 1'b1;
        wake_count        = 32'(htsp_pkg::INIT_DELAY_RST);
        ready_count       = 32'(htsp_pkg::INIT_DELAY_RST);
        interval_count    = htsp_pkg::INTERVAL_NEVER;
        hum_store         = '0;
        temp_store        = '0;
        store_valid       = 1'b0;
    endfunction

    // a request wakes the sequencer once the ready wait has run out
    function automatic bit take_measure_request();
        if (meas_active) begin
            return 1'b0;
        end
        meas_active = 1'b1;
        wake_armed  = 1'b1;
        wake_count  = ready_count;
        return 1'b1;
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [31:0] data);
        case (idx)
            htsp_pkg::REG_UPDATE_INTERVAL: begin
                cfg_interval   = data;
                interval_count = data;
                // a finite interval also asks for a measurement at once
                if (data != htsp_pkg::INTERVAL_NEVER) begin
                    void'(take_measure_request());
                end
            end
            htsp_pkg::REG_INIT_DELAY:     cfg_init_delay    = data[7:0];
            htsp_pkg::REG_MEASURE_DELAY:  cfg_measure_delay = data[7:0];
            htsp_pkg::REG_DEVICE_ADDRESS: cfg_address       = data[6:0];
            default: ;
        endcase
    endfunction

    // one event in, one result word out
    function automatic t_reading advance_poller(logic [1:0] cmd, logic ok,
                                                logic [15:0] t_word,
                                                logic [15:0] h_word);
        t_reading    r;
        int unsigned hum_q;
        int unsigned temp_q;
        r = '0;
        case (cmd)
            htsp_pkg::CMD_TICK: begin
                if (ready_count != 0) begin
                    ready_count--;
                end
                if (cfg_interval != htsp_pkg::INTERVAL_NEVER) begin
                    if (interval_count != 0) begin
                        interval_count--;
                    end
                    if (interval_count == 0) begin
                        void'(take_measure_request());
                        interval_count = cfg_interval;
                    end
                end
                if (wake_armed) begin
                    if (wake_count != 0) begin
                        wake_count--;
                    end
                    // wake: the current phase issues its transfer
                    if (wake_count == 0 && !bus_pending) begin
                        wake_armed  = 1'b0;
                        bus_pending = 1'b1;
                        case (seq_phase)
                            SEQ_SOFT_RESET: begin
                                r.bus_action = htsp_pkg::ACT_WR_RST;
                                r.bus_word   = htsp_pkg::WORD_SOFT_RESET;
                            end
                            SEQ_MEASURE: begin
                                r.bus_action = htsp_pkg::ACT_WR_MEAS;
                                r.bus_word   = htsp_pkg::WORD_MEASURE;
                            end
                            default: r.bus_action = htsp_pkg::ACT_RD_DATA;
                        endcase
                    end
                end
            end
            htsp_pkg::CMD_MEASURE: r.measure_accepted = take_measure_request();
            htsp_pkg::CMD_BUS_DONE: begin
                // a completion with nothing outstanding is dropped
                if (bus_pending) begin
                    bus_pending = 1'b0;
                    if (!ok) begin
                        store_valid  = 1'b0;
                        meas_active  = 1'b0;
                        wake_armed   = 1'b0;
                        seq_phase    = SEQ_SOFT_RESET;
                        r.event_code = htsp_pkg::EVT_ERROR;
                    end else if (seq_phase == SEQ_SOFT_RESET) begin
                        seq_phase   = SEQ_MEASURE;
                        ready_count = 32'(cfg_init_delay);
                        if (meas_active) begin
                            wake_armed = 1'b1;
                            wake_count = 32'(cfg_init_delay);
                        end
                    end else if (seq_phase == SEQ_MEASURE) begin
                        seq_phase  = SEQ_READ;
                        wake_armed = 1'b1;
                        wake_count = 32'(cfg_measure_delay);
                    end else begin
                        temp_store   = t_word;
                        hum_store    = h_word;
                        store_valid  = 1'b1;
                        meas_active  = 1'b0;
                        wake_armed   = 1'b0;
                        seq_phase    = SEQ_MEASURE;
                        r.event_code = htsp_pkg::EVT_UPDATE;
                    end
                end
            end
            default: ;
        endcase

        // hundredths, rounded to nearest; humidity saturates
        hum_q = (32'(hum_store) * 32'(htsp_pkg::HUM_SCALE) + 32'(htsp_pkg::ROUND_HALF))
              / 32'(htsp_pkg::FULL_SCALE);
        if (hum_q > 32'(htsp_pkg::HUM_MAX)) begin
            hum_q = 32'(htsp_pkg::HUM_MAX);
        end
        temp_q = (32'(temp_store) * 32'(htsp_pkg::TEMP_SCALE) + 32'(htsp_pkg::ROUND_HALF))
               / 32'(htsp_pkg::FULL_SCALE);

        r.bus_address     = (r.bus_action != htsp_pkg::ACT_NONE) ? cfg_address : '0;
        r.readings_valid  = store_valid;
        r.humidity_raw    = hum_store;
        r.temperature_raw = temp_store;
        r.humidity_pct    = 14'(hum_q);
        r.temp_centi_c    = 15'(temp_q - 32'(htsp_pkg::TEMP_OFFSET));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // present one event word after a random gap and wait for it to be taken;
    // valid stays high afterwards so a zero gap runs back to back
    task automatic offer_event(input logic [1:0] cmd, input logic ok,
                               input logic [15:0] t_word, input logic [15:0] h_word,
                               output t_reading predicted);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cmd            <= cmd;
        i_bus_ok         <= ok;
        i_read_temp_word <= t_word;
        i_read_hum_word  <= h_word;
        do @(posedge i_clk); while (o_in_stall);
        predicted = advance_poller(cmd, ok, t_word, h_word);
    endtask

    // hold the input side until every expected word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    // write all four registers back to back; unused data bits carry noise
    task automatic configure(input logic [31:0] interval, input logic [7:0] init_dly,
                             input logic [7:0] meas_dly, input logic [6:0] addr);
        logic [1:0]  regs [4] = '{htsp_pkg::REG_UPDATE_INTERVAL, htsp_pkg::REG_INIT_DELAY,
                                  htsp_pkg::REG_MEASURE_DELAY, htsp_pkg::REG_DEVICE_ADDRESS};
        logic [31:0] words [4];
        words[0] = interval;
        words[1] = ($urandom() & 32'hFFFF_FF00) | 32'(init_dly);
        words[2] = ($urandom() & 32'hFFFF_FF00) | 32'(meas_dly);
        words[3] = ($urandom() & 32'hFFFF_FF80) | 32'(addr);
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            i_cfg_index <= regs[k];
            i_cfg_data  <= words[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_register(regs[k], words[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // random event stream, mostly well-formed: completions follow the
    // transfers the poller asks for, with failures, stray events and
    // undefined codes mixed in; ignored words are not counted
    task automatic run_random(input int unsigned count);
        t_reading    predicted;
        logic [1:0]  cmd;
        logic        ok;
        int unsigned roll;
        int unsigned counted;
        counted = 0;
        while (counted < count) begin
            if (counted % 40 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            // mid-stream pause until everything is back
            if (counted == count / 2) begin
                drain();
            end
            roll = $urandom_range(0, 99);
            ok   = 1'($urandom_range(0, 1));
            if (bus_pending && roll < 60) begin
                cmd = htsp_pkg::CMD_BUS_DONE;
                ok  = ($urandom_range(0, 24) != 0);
            end else if (roll < 66) begin
                cmd = CMD_UNUSED;
            end else if (roll < 72) begin
                cmd = htsp_pkg::CMD_BUS_DONE;
            end else if (roll < 80) begin
                cmd = htsp_pkg::CMD_MEASURE;
            end else begin
                cmd = htsp_pkg::CMD_TICK;
            end
            if (cmd != CMD_UNUSED && !(cmd == htsp_pkg::CMD_BUS_DONE && !bus_pending)) begin
                counted++;
            end
            offer_event(cmd, ok, 16'($urandom()), 16'($urandom()), predicted);
            pending_readings.push_back(predicted);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall, then compare against the oldest prediction
    // ------------------------------------------------------------------------

    function automatic void check_field(string field, logic signed [31:0] exp_val,
                                        logic signed [31:0] got_val);
        if (got_val !== exp_val) begin
            faults++;
            $error("%s: expected %0d, got %0d", field, exp_val, got_val);
        end
    endfunction

    initial begin
        t_reading    got;
        t_reading    exp_r;
        int unsigned hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 8);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            got = {o_bus_action, o_bus_word, o_bus_address, o_event_code,
                   o_measure_accepted, o_readings_valid, o_humidity_raw_out,
                   o_temperature_raw_out, o_humidity_pct, o_temp_centi_c};
            if (pending_readings.size() == 0) begin
                faults++;
                $error("result word with nothing expected");
            end else begin
                exp_r = pending_readings.pop_front();
                check_field("bus_action", 32'(exp_r.bus_action), 32'(got.bus_action));
                check_field("bus_word", 32'(exp_r.bus_word), 32'(got.bus_word));
                check_field("bus_address", 32'(exp_r.bus_address), 32'(got.bus_address));
                check_field("event_code", 32'(exp_r.event_code), 32'(got.event_code));
                check_field("measure_accepted", 32'(exp_r.measure_accepted),
                            32'(got.measure_accepted));
                check_field("readings_valid", 32'(exp_r.readings_valid),
                            32'(got.readings_valid));
                check_field("humidity_raw_out", 32'(exp_r.humidity_raw),
                            32'(got.humidity_raw));
                check_field("temperature_raw_out", 32'(exp_r.temperature_raw),
                            32'(got.temperature_raw));
                check_field("humidity_pct", 32'(exp_r.humidity_pct), 32'(got.humidity_pct));
                check_field("temp_centi_c", 32'($signed(exp_r.temp_centi_c)),
                            32'($signed(got.temp_centi_c)));
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        t_reading      predicted;
        t_bringup_step step;
        reset_poller_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bring-up with zero delays so each phase follows the previous one
        configure(htsp_pkg::INTERVAL_NEVER, 8'd0, 8'd0, htsp_pkg::DEV_ADDR_RST);
        foreach (bringup_steps[i]) begin
            step = bringup_steps[i];
            for (int unsigned n = 0; n < step.repeats; n++) begin
                offer_event(step.cmd, step.bus_ok, step.temp_word, step.hum_word,
                            predicted);
                if (step.pinned) begin
                    predicted.bus_action   = step.bus_action;
                    predicted.event_code   = step.event_code;
                    predicted.humidity_pct = step.humidity_pct;
                    predicted.temp_centi_c = step.temp_centi_c;
                end
                pending_readings.push_back(predicted);
            end
        end

        // random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: configure(htsp_pkg::INTERVAL_NEVER, 8'd0, 8'd0, 7'd0);
                // interval zero: a request on every tick
                1: configure(32'd0, 8'd1, 8'd2, 7'h7F);
                2: configure(32'($urandom_range(2, 12)), 8'($urandom_range(0, 4)),
                             8'($urandom_range(0, 6)), 7'($urandom_range(0, 127)));
                // longest delays, interval just short of never
                3: configure(32'hFFFF_FFFE, 8'hFF, 8'hFF, htsp_pkg::DEV_ADDR_RST);
                4: configure(32'd25, 8'd3, 8'd1, 7'($urandom_range(0, 127)));
                default: configure(htsp_pkg::INTERVAL_NEVER, htsp_pkg::INIT_DELAY_RST,
                                   htsp_pkg::MEASURE_DELAY_RST, htsp_pkg::DEV_ADDR_RST);
            endcase
            run_random((p == 3) ? 100 : 180);
        end

        drain();
        // two register stages: give any stray word time to show
        repeat (4) @(posedge i_clk);
        if (pending_readings.size() != 0) begin
            faults++;
            $error("%0d expected result words never arrived", pending_readings.size());
        end
        if (faults == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
